@@ design/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the triangle plane clipper
// Fixed-point widths, register indexes and the divider step record.
// ----------------------------------------------------------------------------
`default_nettype none
package tpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;             // coordinate width
  localparam int DIFW      = CW + 1;         // coordinate difference width
  localparam int PRW       = 2 * CW + 1;     // n * (v - p) width
  localparam int DW        = PRW + 2;        // plane distance width
  localparam int RW        = DW + 2;         // remainder and divisor width
  localparam int QW        = FRAC_BITS;      // edge parameter width
  localparam int MW        = DIFW + QW + 1;  // (b - a) * t width
  localparam int SHW       = MW - FRAC_BITS; // width after the fraction shift
  localparam int SUMW      = SHW + 1;        // a + step width

  localparam logic [2:0] REG_POINT_X  = 3'd0;
  localparam logic [2:0] REG_POINT_Y  = 3'd1;
  localparam logic [2:0] REG_POINT_Z  = 3'd2;
  localparam logic [2:0] REG_NORMAL_X = 3'd3;
  localparam logic [2:0] REG_NORMAL_Y = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z = 3'd5;

  typedef enum logic [1:0] {
    K_FULL = 2'd0,
    K_ONE  = 2'd1,
    K_TWO  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] den;
    logic [QW-1:0] q;
  } div_t;

endpackage
`default_nettype wire

@@ design/triangle_plane_clipper.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_clipper: clips one triangle against a configured plane
// Signed distances, edge intersection and saturation in a deep pipeline.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                        | Direction | Moves
//  --------+------------------------------+-----------+-------------------------
//  in      | in_valid/in_ready, in_*      | input     | one triangle
//  out     | out_valid/out_ready, out_*   | output    | one clipped triangle
//  cfg     | cfg_valid/cfg_ready, cfg_*   | input     | one plane register write
//
// A triangle can enter in every cycle while the output does not stall. The
// restoring divider, one quotient bit per stage, makes the pipeline deep. A
// triangle that leaves a quad produces two output transactions, so the whole
// pipeline holds until the second of them leaves.
// Reset clears all valid bits and loads the plane registers (normal +z).
// A stall on the output freezes every stage at once; nothing is dropped.
`default_nettype none
module triangle_plane_clipper (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input triangle
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v0_x,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v0_y,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v0_z,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v1_x,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v1_y,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v1_z,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v2_x,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v2_y,
  input  wire logic signed [tpc_pkg::CW-1:0] in_v2_z,
  input  wire logic [15:0]                   in_glyph,
  input  wire logic [7:0]                    in_colour,
  // result triangle
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [tpc_pkg::CW-1:0]      out_v0_x,
  output logic signed [tpc_pkg::CW-1:0]      out_v0_y,
  output logic signed [tpc_pkg::CW-1:0]      out_v0_z,
  output logic signed [tpc_pkg::CW-1:0]      out_v1_x,
  output logic signed [tpc_pkg::CW-1:0]      out_v1_y,
  output logic signed [tpc_pkg::CW-1:0]      out_v1_z,
  output logic signed [tpc_pkg::CW-1:0]      out_v2_x,
  output logic signed [tpc_pkg::CW-1:0]      out_v2_y,
  output logic signed [tpc_pkg::CW-1:0]      out_v2_z,
  output logic [15:0]                        out_glyph,
  output logic [7:0]                         out_colour,
  output logic                               out_last,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [tpc_pkg::CW-1:0]        cfg_data
);
  import tpc_pkg::*;

  // Everything that rides alongside the divider lanes.
  typedef struct packed {
    logic                          vld;
    kind_t                         kind;
    logic [1:0]                    ja;
    logic [1:0]                    jb;
    logic [15:0]                   glyph;
    logic [7:0]                    colour;
    logic [8:0][CW-1:0]            v;
    logic [1:0][2:0][DIFW-1:0]     dba;
  } com_t;

  // Plane registers. The write port is always ready.
  logic signed [CW-1:0] pp_r [3];
  logic signed [CW-1:0] pn_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r[0] <= '0;
      pp_r[1] <= '0;
      pp_r[2] <= '0;
      pn_r[0] <= '0;
      pn_r[1] <= '0;
      pn_r[2] <= CW'(1) <<< FRAC_BITS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POINT_X:  pp_r[0] <= cfg_data;
        REG_POINT_Y:  pp_r[1] <= cfg_data;
        REG_POINT_Z:  pp_r[2] <= cfg_data;
        REG_NORMAL_X: pn_r[0] <= cfg_data;
        REG_NORMAL_Y: pn_r[1] <= cfg_data;
        REG_NORMAL_Z: pn_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A single enable moves every stage. The output stage can take a new
  // triangle when it is empty or when its last transaction leaves now.
  logic en;
  logic ov_r;
  assign en       = !ov_r || (out_ready && out_last);
  assign in_ready = en;

  logic signed [CW-1:0] vin [9];
  assign vin[0] = in_v0_x;
  assign vin[1] = in_v0_y;
  assign vin[2] = in_v0_z;
  assign vin[3] = in_v1_x;
  assign vin[4] = in_v1_y;
  assign vin[5] = in_v1_z;
  assign vin[6] = in_v2_x;
  assign vin[7] = in_v2_y;
  assign vin[8] = in_v2_z;

  // Stage 1: coordinate minus plane point.
  logic                   vld1_r, vld2_r, vld3_r;
  logic signed [CW-1:0]   v1_r [9];
  logic signed [CW-1:0]   v2_r [9];
  logic signed [CW-1:0]   v3_r [9];
  logic [15:0]            g1_r, g2_r, g3_r;
  logic [7:0]             c1_r, c2_r, c3_r;
  logic signed [DIFW-1:0] dvp1_r [9];
  logic signed [PRW-1:0]  prod2_r [9];
  logic signed [DW-1:0]   d3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r <= in_glyph;
      c1_r <= in_colour;
      g2_r <= g1_r;
      c2_r <= c1_r;
      g3_r <= g2_r;
      c3_r <= c2_r;
      for (int i = 0; i < 9; i++) begin
        v1_r[i]    <= vin[i];
        dvp1_r[i]  <= DIFW'(vin[i]) - DIFW'(pp_r[i % 3]);
        v2_r[i]    <= v1_r[i];
        // Stage 2: one product per coordinate.
        prod2_r[i] <= PRW'(dvp1_r[i]) * PRW'(pn_r[i % 3]);
        v3_r[i]    <= v2_r[i];
      end
      // Stage 3: the three products of each vertex are summed.
      for (int j = 0; j < 3; j++) begin
        d3_r[j] <= DW'(prod2_r[3*j]) + DW'(prod2_r[3*j+1]) + DW'(prod2_r[3*j+2]);
      end
    end
  end

  // Stage 4: classify the vertices and set up both intersection lanes.
  // Inside vertices keep input order; lane A crosses from the first inside
  // vertex, lane B from the second inside vertex of a quad.
  logic [2:0] neg;
  kind_t      kind4;
  logic       keep4;
  logic [1:0] ja4, jb4, oa4, ob4;

  always_comb begin
    neg   = {d3_r[2][DW-1], d3_r[1][DW-1], d3_r[0][DW-1]};
    kind4 = K_FULL;
    keep4 = 1'b1;
    ja4   = 2'd0;
    jb4   = 2'd0;
    oa4   = 2'd0;
    ob4   = 2'd0;
    case (neg)
      3'b000: begin
        kind4 = K_FULL;
      end
      3'b001: begin
        kind4 = K_TWO; ja4 = 2'd1; jb4 = 2'd2; oa4 = 2'd0; ob4 = 2'd0;
      end
      3'b010: begin
        kind4 = K_TWO; ja4 = 2'd0; jb4 = 2'd2; oa4 = 2'd1; ob4 = 2'd1;
      end
      3'b100: begin
        kind4 = K_TWO; ja4 = 2'd0; jb4 = 2'd1; oa4 = 2'd2; ob4 = 2'd2;
      end
      3'b011: begin
        kind4 = K_ONE; ja4 = 2'd2; jb4 = 2'd2; oa4 = 2'd0; ob4 = 2'd1;
      end
      3'b101: begin
        kind4 = K_ONE; ja4 = 2'd1; jb4 = 2'd1; oa4 = 2'd0; ob4 = 2'd2;
      end
      3'b110: begin
        kind4 = K_ONE; ja4 = 2'd0; jb4 = 2'd0; oa4 = 2'd1; ob4 = 2'd2;
      end
      default: begin
        keep4 = 1'b0;
      end
    endcase
  end

  com_t com_r [QW+1];
  div_t div_q [QW+1][2];
  div_t div4_r [2];

  assign div_q[0][0] = div4_r[0];
  assign div_q[0][1] = div4_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      com_r[0].vld <= 1'b0;
    end else if (en) begin
      com_r[0].vld <= vld3_r && keep4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      com_r[0].kind   <= kind4;
      com_r[0].ja     <= ja4;
      com_r[0].jb     <= jb4;
      com_r[0].glyph  <= g3_r;
      com_r[0].colour <= c3_r;
      for (int i = 0; i < 9; i++) begin
        com_r[0].v[i] <= v3_r[i];
      end
      for (int k = 0; k < 3; k++) begin
        com_r[0].dba[0][k] <= DIFW'(v3_r[3*oa4+k]) - DIFW'(v3_r[3*ja4+k]);
        com_r[0].dba[1][k] <= DIFW'(v3_r[3*ob4+k]) - DIFW'(v3_r[3*jb4+k]);
      end
      div4_r[0].rem <= RW'(d3_r[ja4]);
      div4_r[0].den <= RW'(d3_r[ja4]) - RW'(d3_r[oa4]);
      div4_r[0].q   <= '0;
      div4_r[1].rem <= RW'(d3_r[jb4]);
      div4_r[1].den <= RW'(d3_r[jb4]) - RW'(d3_r[ob4]);
      div4_r[1].q   <= '0;
    end
  end

  // Divider: one quotient bit per stage in each lane.
  for (genvar s = 0; s < QW; s++) begin : g_div
    for (genvar l = 0; l < 2; l++) begin : g_lane
      tpc_div_step u_step (
        .clk (clk),
        .en  (en),
        .d_i (div_q[s][l]),
        .d_o (div_q[s+1][l])
      );
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        com_r[s+1].vld <= 1'b0;
      end else if (en) begin
        com_r[s+1].vld <= com_r[s].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        com_r[s+1].kind   <= com_r[s].kind;
        com_r[s+1].ja     <= com_r[s].ja;
        com_r[s+1].jb     <= com_r[s].jb;
        com_r[s+1].glyph  <= com_r[s].glyph;
        com_r[s+1].colour <= com_r[s].colour;
        com_r[s+1].v      <= com_r[s].v;
        com_r[s+1].dba    <= com_r[s].dba;
      end
    end
  end

  // Stage M: (b - a) * t per coordinate of both lanes.
  com_t                  comm_r, comx_r;
  logic signed [MW-1:0]  mul_r [2][3];
  logic signed [CW-1:0]  x_r [2][3];
  com_t                  cq;
  assign cq = com_r[QW];

  // Stage X: a + floor(product / 2^FRAC_BITS), saturated.
  logic signed [SUMW-1:0] xs [2][3];
  logic signed [CW-1:0]   xa [2][3];
  logic [1:0]             srcm [2];

  always_comb begin
    srcm[0] = comm_r.ja;
    srcm[1] = comm_r.jb;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        xa[l][k] = comm_r.v[3*srcm[l]+k];
        xs[l][k] = SUMW'(xa[l][k]) + SUMW'(SHW'(mul_r[l][k] >>> FRAC_BITS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comm_r.vld <= 1'b0;
      comx_r.vld <= 1'b0;
    end else if (en) begin
      comm_r.vld <= cq.vld;
      comx_r.vld <= comm_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comm_r.kind   <= cq.kind;
      comm_r.ja     <= cq.ja;
      comm_r.jb     <= cq.jb;
      comm_r.glyph  <= cq.glyph;
      comm_r.colour <= cq.colour;
      comm_r.v      <= cq.v;
      comm_r.dba    <= cq.dba;
      comx_r.kind   <= comm_r.kind;
      comx_r.ja     <= comm_r.ja;
      comx_r.jb     <= comm_r.jb;
      comx_r.glyph  <= comm_r.glyph;
      comx_r.colour <= comm_r.colour;
      comx_r.v      <= comm_r.v;
      comx_r.dba    <= comm_r.dba;
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          mul_r[l][k] <= MW'($signed(cq.dba[l][k])) *
                         MW'($signed({1'b0, div_q[QW][l].q}));
          if (xs[l][k] > SUMW'(32'sh7fffffff)) begin
            x_r[l][k] <= 32'sh7fffffff;
          end else if (xs[l][k] < -SUMW'(33'sh080000000)) begin
            x_r[l][k] <= 32'sh80000000;
          end else begin
            x_r[l][k] <= CW'(xs[l][k]);
          end
        end
      end
    end
  end

  // Output stage: both result triangles are assembled, then shown in turn.
  logic                 ph_r, two_r;
  logic signed [CW-1:0] t0_nxt [9];
  logic signed [CW-1:0] t1_nxt [9];
  logic signed [CW-1:0] t0_r [9];
  logic signed [CW-1:0] t1_r [9];
  logic [15:0]          og_r;
  logic [7:0]           oc_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (comx_r.kind)
        K_ONE: begin
          t0_nxt[k]   = comx_r.v[3*comx_r.ja+k];
          t0_nxt[3+k] = x_r[0][k];
          t0_nxt[6+k] = x_r[1][k];
        end
        K_TWO: begin
          t0_nxt[k]   = comx_r.v[3*comx_r.ja+k];
          t0_nxt[3+k] = comx_r.v[3*comx_r.jb+k];
          t0_nxt[6+k] = x_r[0][k];
        end
        default: begin
          t0_nxt[k]   = comx_r.v[k];
          t0_nxt[3+k] = comx_r.v[3+k];
          t0_nxt[6+k] = comx_r.v[6+k];
        end
      endcase
      t1_nxt[k]   = comx_r.v[3*comx_r.jb+k];
      t1_nxt[3+k] = x_r[0][k];
      t1_nxt[6+k] = x_r[1][k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      ph_r  <= 1'b0;
      two_r <= 1'b0;
    end else if (en) begin
      ov_r  <= comx_r.vld;
      ph_r  <= 1'b0;
      two_r <= (comx_r.kind == K_TWO);
    end else if (out_ready) begin
      // First half of a quad has gone; the second one follows.
      ph_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      og_r <= comx_r.glyph;
      oc_r <= comx_r.colour;
      for (int i = 0; i < 9; i++) begin
        t0_r[i] <= t0_nxt[i];
        t1_r[i] <= t1_nxt[i];
      end
    end
  end

  assign out_valid  = ov_r;
  assign out_last   = !two_r || ph_r;
  assign out_glyph  = og_r;
  assign out_colour = oc_r;
  assign out_v0_x   = ph_r ? t1_r[0] : t0_r[0];
  assign out_v0_y   = ph_r ? t1_r[1] : t0_r[1];
  assign out_v0_z   = ph_r ? t1_r[2] : t0_r[2];
  assign out_v1_x   = ph_r ? t1_r[3] : t0_r[3];
  assign out_v1_y   = ph_r ? t1_r[4] : t0_r[4];
  assign out_v1_z   = ph_r ? t1_r[5] : t0_r[5];
  assign out_v2_x   = ph_r ? t1_r[6] : t0_r[6];
  assign out_v2_y   = ph_r ? t1_r[7] : t0_r[7];
  assign out_v2_z   = ph_r ? t1_r[8] : t0_r[8];

endmodule
`default_nettype wire

@@ design/tpc_div_step.sv @@
// ----------------------------------------------------------------------------
// tpc_div_step: one registered restoring division step
// Produces one quotient bit of the edge parameter per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tpc_div_step (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire tpc_pkg::div_t d_i,
  output tpc_pkg::div_t     d_o
);
  import tpc_pkg::*;

  logic [RW-1:0] rem2;
  div_t          nxt;

  always_comb begin
    rem2    = {d_i.rem[RW-2:0], 1'b0};
    nxt.den = d_i.den;
    if (rem2 >= d_i.den) begin
      nxt.rem = rem2 - d_i.den;
      nxt.q   = {d_i.q[QW-2:0], 1'b1};
    end else begin
      nxt.rem = rem2;
      nxt.q   = {d_i.q[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= nxt;
    end
  end

endmodule
`default_nettype wire
